// File: rtl/okc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okc_pkg
// Shared types and constants of the oven keypad countdown controller.
// ----------------------------------------------------------------------------
package okc_pkg;

    localparam int TIME_WIDTH_DEF = 16;

    // item kinds
    localparam logic [1:0] FUNC_CHAR = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;

    // key codes
    localparam logic [7:0] KEY_ZERO   = 8'd48;
    localparam logic [7:0] KEY_NINE   = 8'd57;
    localparam logic [7:0] KEY_CANCEL = 8'd60;
    localparam logic [7:0] KEY_EQ     = 8'd61;

    localparam logic [9:0] MIN_MAX     = 10'd1023;
    localparam logic [6:0] SEC_RELOAD  = 7'd59;
    localparam logic [7:0] DUTY_OFFSET = 8'd40;

    typedef enum logic [1:0] {
        PH_AWAIT_MODE  = 2'd0,
        PH_ENTER_TIME  = 2'd1,
        PH_AWAIT_START = 2'd2,
        PH_RUNNING     = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0] phase;
        logic       motor_on;
        logic [7:0] motor_duty;
        logic [9:0] minutes_left;
        logic [6:0] seconds_left;
        logic       digit_echo;
        logic       finished;
        logic       aborted;
        logic [7:0] mode_code;
    } t_out_item;

endpackage
`default_nettype wire

// File: rtl/oven_keypad_countdown_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oven_keypad_countdown_controller_top
// Keypad-driven oven controller: mode key, time entry, start/cancel, countdown.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle (key character, one-second tick or stop
// button) and returns exactly one result transaction for each, showing the
// state after the item. Each item is handled by the combinational phase
// logic and lands in an output register, so input is accepted every cycle
// unless that register holds a result that is stalled downstream. The entered
// time is split into minutes and seconds by a registered reciprocal multiply
// fed from the digit register; the phase sequence always leaves at least one
// item between the last digit and the start key, so this costs no throughput.
module oven_keypad_countdown_controller_top #(
    parameter int TIME_WIDTH = okc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire okc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output okc_pkg::t_out_item      o_out_item
);

    okc_pkg::t_phase         r_phase, n_phase;
    logic [7:0]              r_mode, n_mode;
    logic [TIME_WIDTH-1:0]   r_entered, n_entered;
    logic [9:0]              r_minutes, n_minutes;
    logic [6:0]              r_seconds, n_seconds;
    logic                    r_stop_pending, n_stop_pending;
    logic                    r_out_valid;
    okc_pkg::t_out_item      r_out_item, n_out_item;

    logic                    w_accept;
    logic                    w_echo, w_fin, w_abt;
    logic [9:0]              w_split_min;
    logic [6:0]              w_split_sec;
    logic [3:0]              w_digit;
    logic                    w_is_digit;
    logic [9:0]              w_tick_min;
    logic [6:0]              w_tick_sec;
    logic [7:0]              w_duty_base;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    okc_time_split #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_split (
        .i_clk    (i_clk),
        .i_time   (r_entered),
        .o_minutes(w_split_min),
        .o_seconds(w_split_sec)
    );

    assign w_is_digit = (i_in_item.char_code >= okc_pkg::KEY_ZERO) &&
                        (i_in_item.char_code <= okc_pkg::KEY_NINE);
    assign w_digit    = 4'(i_in_item.char_code - okc_pkg::KEY_ZERO);

    // one-second countdown step with minute borrow
    always_comb begin
        w_tick_min = r_minutes;
        w_tick_sec = r_seconds;
        if (r_seconds == 7'd0) begin
            if (r_minutes != 10'd0) begin
                w_tick_min = r_minutes - 10'd1;
                w_tick_sec = okc_pkg::SEC_RELOAD;
            end
        end else begin
            w_tick_sec = r_seconds - 7'd1;
        end
    end

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_mode         = r_mode;
        n_entered      = r_entered;
        n_minutes      = r_minutes;
        n_seconds      = r_seconds;
        n_stop_pending = r_stop_pending;
        w_echo         = 1'b0;
        w_fin          = 1'b0;
        w_abt          = 1'b0;
        priority if (i_in_item.func == okc_pkg::FUNC_STOP) begin
            if (r_phase == okc_pkg::PH_RUNNING) begin
                w_abt          = 1'b1;
                n_phase        = okc_pkg::PH_AWAIT_MODE;
                n_stop_pending = 1'b0;
            end else begin
                n_stop_pending = 1'b1;
            end
        end else if (i_in_item.func == okc_pkg::FUNC_TICK) begin
            if (r_phase == okc_pkg::PH_RUNNING) begin
                n_minutes = w_tick_min;
                n_seconds = w_tick_sec;
                if (w_tick_min == 10'd0 && w_tick_sec == 7'd0) begin
                    w_fin          = 1'b1;
                    n_phase        = okc_pkg::PH_AWAIT_MODE;
                    n_stop_pending = 1'b0;
                end
            end
        end else if (i_in_item.func == okc_pkg::FUNC_CHAR) begin
            unique case (r_phase)
                okc_pkg::PH_AWAIT_MODE: begin
                    n_mode    = i_in_item.char_code;
                    n_entered = '0;
                    n_phase   = okc_pkg::PH_ENTER_TIME;
                end
                okc_pkg::PH_ENTER_TIME: begin
                    if (w_is_digit) begin
                        n_entered = (r_entered << 3) + (r_entered << 1)
                                  + TIME_WIDTH'(w_digit);
                        w_echo    = 1'b1;
                    end else if (i_in_item.char_code == okc_pkg::KEY_EQ) begin
                        n_phase = okc_pkg::PH_AWAIT_START;
                    end
                end
                okc_pkg::PH_AWAIT_START: begin
                    if (i_in_item.char_code == okc_pkg::KEY_EQ) begin
                        if (r_stop_pending) begin
                            n_phase        = okc_pkg::PH_AWAIT_MODE;
                            n_stop_pending = 1'b0;
                        end else begin
                            n_minutes = w_split_min;
                            n_seconds = w_split_sec;
                            if (w_split_min == 10'd0 && w_split_sec == 7'd0) begin
                                w_fin   = 1'b1;
                                n_phase = okc_pkg::PH_AWAIT_MODE;
                            end else begin
                                n_phase = okc_pkg::PH_RUNNING;
                            end
                        end
                    end else if (i_in_item.char_code == okc_pkg::KEY_CANCEL) begin
                        n_phase        = okc_pkg::PH_AWAIT_MODE;
                        n_stop_pending = 1'b0;
                    end
                end
                okc_pkg::PH_RUNNING: begin
                end
                default: begin
                end
            endcase
        end else begin
            // unused item kind changes nothing
        end
    end

    assign w_duty_base = n_mode - okc_pkg::DUTY_OFFSET;

    // result outputs, taken from the state after the item
    always_comb begin
        n_out_item              = '0;
        n_out_item.phase        = n_phase;
        n_out_item.motor_on     = (n_phase == okc_pkg::PH_RUNNING);
        n_out_item.motor_duty   = (n_phase == okc_pkg::PH_RUNNING)
                                ? 8'((w_duty_base << 3) + (w_duty_base << 1)) : 8'd0;
        n_out_item.minutes_left = n_minutes;
        n_out_item.seconds_left = n_seconds;
        n_out_item.digit_echo   = w_echo;
        n_out_item.finished     = w_fin;
        n_out_item.aborted      = w_abt;
        n_out_item.mode_code    = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= okc_pkg::PH_AWAIT_MODE;
            r_mode         <= '0;
            r_entered      <= '0;
            r_minutes      <= '0;
            r_seconds      <= '0;
            r_stop_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase        <= n_phase;
                r_mode         <= n_mode;
                r_entered      <= n_entered;
                r_minutes      <= n_minutes;
                r_seconds      <= n_seconds;
                r_stop_pending <= n_stop_pending;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/okc_time_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okc_time_split
// Splits the entered number into minutes (value / 100, saturated) and
// seconds (value % 100) with a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module okc_time_split #(
    parameter int TIME_WIDTH = okc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic [TIME_WIDTH-1:0] i_time,
    output logic      [9:0]            o_minutes,
    output logic      [6:0]            o_seconds
);

    localparam int SHIFT = TIME_WIDTH + 7;
    localparam int QW    = TIME_WIDTH - 6;
    localparam int PW    = 2 * TIME_WIDTH + 1;
    localparam int CW    = (QW > 10) ? QW : 10;
    // ceil(2^SHIFT / 100), exact quotient for every TIME_WIDTH-bit value
    localparam logic [TIME_WIDTH:0] RECIP =
        (TIME_WIDTH + 1)'(((64'd1 << SHIFT) + 64'd99) / 64'd100);

    logic [PW-1:0] w_prod;
    logic [QW-1:0] r_quot;
    logic [6:0]    r_low;
    logic [CW-1:0] w_quot_ext;

    assign w_prod = PW'(i_time) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_quot <= w_prod[SHIFT +: QW];
        r_low  <= i_time[6:0];
    end

    assign w_quot_ext = CW'(r_quot);
    assign o_minutes  = (w_quot_ext > CW'(okc_pkg::MIN_MAX)) ? okc_pkg::MIN_MAX
                                                             : w_quot_ext[9:0];
    // remainder is below 100, so 7-bit wraparound arithmetic is exact
    assign o_seconds  = r_low - 7'(7'(r_quot) * 7'd100);

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oven keypad countdown controller.
// ----------------------------------------------------------------------------
// A clocked driver feeds key, tick and stop transactions from a backlog that
// the stimulus process fills: a directed opening, then random keypad sessions
// (mode key, digits, start or cancel, countdown ticks, stops) salted with
// stray keys. Each accepted transaction is run through a local model of the
// phase logic and countdown, and the monitor checks every result field in
// order. Sender and receiver idle at several mixes, and once the receiver
// holds off long enough for the block to back up and stall its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int          TW          = okc_pkg::TIME_WIDTH_DEF;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          HOLD_CYCLES = 200;
    localparam int          BATCH_ITEMS = 450;
    localparam int          MAX_REPORTS = 40;
    localparam longint      TIMEOUT_NS  = 64'd5_000_000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    okc_pkg::t_in_item  i_in_item   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    okc_pkg::t_out_item o_out_item;

    // local copy of the controller state
    okc_pkg::t_phase ph_q    = okc_pkg::PH_AWAIT_MODE;
    logic [7:0]      mode_q  = '0;
    logic [TW-1:0]   entry_q = '0;
    logic [9:0]      min_q   = '0;
    logic [6:0]      sec_q   = '0;
    logic            stop_q  = 1'b0;

    okc_pkg::t_in_item  key_backlog[$];
    okc_pkg::t_out_item readout_due[$];

    int errors       = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int batch_items  = 0;
    int n_runs       = 0;
    int n_finished   = 0;
    int n_aborted    = 0;
    int n_suppressed = 0;
    int n_cancelled  = 0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic squeeze_go     = 1'b0;
    logic squeeze_done   = 1'b0;
    int   hold_left      = 0;

    oven_keypad_countdown_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // next controller state and the result it shows for one transaction
    function automatic okc_pkg::t_out_item oven_next(okc_pkg::t_in_item it);
        okc_pkg::t_out_item r;
        logic [31:0]        whole_min;
        logic [7:0]         duty_base;
        r = '0;
        case (it.func)
            okc_pkg::FUNC_STOP: begin
                if (ph_q == okc_pkg::PH_RUNNING) begin
                    r.aborted = 1'b1;
                    ph_q      = okc_pkg::PH_AWAIT_MODE;
                    stop_q    = 1'b0;
                    n_aborted++;
                end else begin
                    stop_q = 1'b1;
                end
            end
            okc_pkg::FUNC_TICK: begin
                if (ph_q == okc_pkg::PH_RUNNING) begin
                    if (sec_q == 0) begin
                        if (min_q != 0) begin
                            min_q = min_q - 1'b1;
                            sec_q = okc_pkg::SEC_RELOAD;
                        end
                    end else begin
                        sec_q = sec_q - 1'b1;
                    end
                    if (min_q == 0 && sec_q == 0) begin
                        r.finished = 1'b1;
                        ph_q       = okc_pkg::PH_AWAIT_MODE;
                        stop_q     = 1'b0;
                        n_finished++;
                    end
                end
            end
            okc_pkg::FUNC_CHAR: begin
                case (ph_q)
                    okc_pkg::PH_AWAIT_MODE: begin
                        mode_q  = it.char_code;
                        entry_q = '0;
                        ph_q    = okc_pkg::PH_ENTER_TIME;
                    end
                    okc_pkg::PH_ENTER_TIME: begin
                        if (it.char_code >= okc_pkg::KEY_ZERO &&
                            it.char_code <= okc_pkg::KEY_NINE) begin
                            entry_q      = TW'(entry_q * 10
                                               + (it.char_code - okc_pkg::KEY_ZERO));
                            r.digit_echo = 1'b1;
                        end else if (it.char_code == okc_pkg::KEY_EQ) begin
                            ph_q = okc_pkg::PH_AWAIT_START;
                        end
                    end
                    okc_pkg::PH_AWAIT_START: begin
                        if (it.char_code == okc_pkg::KEY_EQ) begin
                            if (stop_q) begin
                                ph_q   = okc_pkg::PH_AWAIT_MODE;
                                stop_q = 1'b0;
                                n_suppressed++;
                            end else begin
                                whole_min = entry_q / 100;
                                min_q     = (whole_min > okc_pkg::MIN_MAX)
                                          ? okc_pkg::MIN_MAX : whole_min[9:0];
                                sec_q     = 7'(entry_q % 100);
                                n_runs++;
                                if (min_q == 0 && sec_q == 0) begin
                                    r.finished = 1'b1;
                                    ph_q       = okc_pkg::PH_AWAIT_MODE;
                                    n_finished++;
                                end else begin
                                    ph_q = okc_pkg::PH_RUNNING;
                                end
                            end
                        end else if (it.char_code == okc_pkg::KEY_CANCEL) begin
                            ph_q   = okc_pkg::PH_AWAIT_MODE;
                            stop_q = 1'b0;
                            n_cancelled++;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        duty_base      = mode_q - okc_pkg::DUTY_OFFSET;
        r.phase        = ph_q;
        r.motor_on     = (ph_q == okc_pkg::PH_RUNNING);
        r.motor_duty   = (ph_q == okc_pkg::PH_RUNNING) ? duty_base * 8'd10 : 8'd0;
        r.minutes_left = min_q;
        r.seconds_left = sec_q;
        r.mode_code    = mode_q;
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        if (errors < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    task automatic compare_result(okc_pkg::t_out_item got, okc_pkg::t_out_item want);
        string tag;
        tag = $sformatf("result %0d", results_seen);
        if (got.phase !== want.phase)
            flag_mismatch($sformatf("%s phase %0d, want %0d", tag, got.phase, want.phase));
        if (got.motor_on !== want.motor_on)
            flag_mismatch($sformatf("%s motor_on %0b, want %0b", tag, got.motor_on,
                                    want.motor_on));
        if (got.motor_duty !== want.motor_duty)
            flag_mismatch($sformatf("%s motor_duty %0d, want %0d", tag, got.motor_duty,
                                    want.motor_duty));
        if (got.minutes_left !== want.minutes_left)
            flag_mismatch($sformatf("%s minutes_left %0d, want %0d", tag, got.minutes_left,
                                    want.minutes_left));
        if (got.seconds_left !== want.seconds_left)
            flag_mismatch($sformatf("%s seconds_left %0d, want %0d", tag, got.seconds_left,
                                    want.seconds_left));
        if (got.digit_echo !== want.digit_echo)
            flag_mismatch($sformatf("%s digit_echo %0b, want %0b", tag, got.digit_echo,
                                    want.digit_echo));
        if (got.finished !== want.finished)
            flag_mismatch($sformatf("%s finished %0b, want %0b", tag, got.finished,
                                    want.finished));
        if (got.aborted !== want.aborted)
            flag_mismatch($sformatf("%s aborted %0b, want %0b", tag, got.aborted,
                                    want.aborted));
        if (got.mode_code !== want.mode_code)
            flag_mismatch($sformatf("%s mode_code %0d, want %0d", tag, got.mode_code,
                                    want.mode_code));
    endtask

    // driver: offers the next backlog item once the current one is taken
    always @(posedge i_clk) begin : driver
        okc_pkg::t_in_item nxt_item;
        logic              nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_item  = i_in_item;
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                readout_due.push_back(oven_next(i_in_item));
                items_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && key_backlog.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt_item  = key_backlog.pop_front();
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
            i_in_item  <= nxt_item;
        end
    end

    // receiver stall, including the one long hold-off
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (squeeze_go && !squeeze_done) begin
            squeeze_done <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        okc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readout_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with none expected (%h)",
                                        results_seen, o_out_item));
            end else begin
                want = readout_due.pop_front();
                compare_result(o_out_item, want);
            end
            results_seen++;
        end
    end

    task automatic add_key(logic [1:0] f, logic [7:0] c);
        okc_pkg::t_in_item it;
        it.func      = f;
        it.char_code = c;
        key_backlog.push_back(it);
        batch_items++;
    endtask

    // any key that is not a digit, start or cancel
    function automatic logic [7:0] stray_key();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while ((c >= okc_pkg::KEY_ZERO && c <= okc_pkg::KEY_NINE) ||
                   c == okc_pkg::KEY_EQ || c == okc_pkg::KEY_CANCEL);
        return c;
    endfunction

    // one keypad session: mode, digits, start or cancel, then the countdown; or a short run of random items
    task automatic queue_session();
        int         ndig;
        int         entered;
        int         total;
        int         ticks;
        int         pick;
        logic [7:0] d;
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 6))
                add_key(2'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        add_key(okc_pkg::FUNC_CHAR, 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 70)      ndig = $urandom_range(1, 2);
        else if (pick < 88) ndig = 3;
        else                ndig = $urandom_range(4, 6);
        entered = 0;
        for (int i = 0; i < ndig; i++) begin
            if ($urandom_range(9) == 0) add_key(okc_pkg::FUNC_CHAR, stray_key());
            d = 8'($urandom_range(9));
            add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_ZERO + d);
            entered = (entered * 10 + d) % (1 << TW);
        end
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
        if ($urandom_range(9) == 0) add_key(okc_pkg::FUNC_CHAR, stray_key());
        if ($urandom_range(9) == 0) add_key(okc_pkg::FUNC_TICK, 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 8) begin
            add_key(okc_pkg::FUNC_STOP, 8'($urandom_range(255)));
            add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
            return;
        end else if (pick < 16) begin
            add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_CANCEL);
            return;
        end
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
        total = (entered / 100) * 60 + entered % 100;
        if (total == 0) return;
        if (total <= 150 && $urandom_range(3) != 0) ticks = total;
        else ticks = $urandom_range(0, 20);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(19) == 0) begin
                if ($urandom_range(1) != 0)
                    add_key(okc_pkg::FUNC_CHAR, 8'($urandom_range(255)));
                else
                    add_key(FUNC_UNUSED, 8'($urandom_range(255)));
            end
            add_key(okc_pkg::FUNC_TICK, 8'($urandom_range(255)));
        end
        // a run cut short ends with the stop button
        if (ticks < total) add_key(okc_pkg::FUNC_STOP, 8'($urandom_range(255)));
        else if ($urandom_range(4) == 0) add_key(okc_pkg::FUNC_TICK, 8'($urandom_range(255)));
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        add_key(FUNC_UNUSED, 8'hFF);
        add_key(okc_pkg::FUNC_TICK, 8'h00);
        add_key(okc_pkg::FUNC_STOP, 8'h00);          // stop before any run is remembered
        add_key(okc_pkg::FUNC_CHAR, 8'hFF);          // mode key at top code
        add_key(okc_pkg::FUNC_CHAR, 8'h3A);          // non-digit ignored
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_ZERO);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_NINE);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
        add_key(okc_pkg::FUNC_TICK, 8'hFF);
        add_key(okc_pkg::FUNC_CHAR, 8'h61);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ); // start swallowed by the pending stop
        add_key(okc_pkg::FUNC_CHAR, 8'h00);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ); // zero time finishes at once
        add_key(okc_pkg::FUNC_CHAR, 8'h28);          // mode with zero duty
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_ZERO + 8'd1);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_ZERO);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_ZERO);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ); // runs from 1:00
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_ZERO + 8'd5);
        add_key(okc_pkg::FUNC_TICK, 8'h00);          // minute borrow
        add_key(okc_pkg::FUNC_STOP, 8'hFF);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_CANCEL); // cancel key taken as a mode
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_EQ);
        add_key(okc_pkg::FUNC_CHAR, okc_pkg::KEY_CANCEL);
        while (key_backlog.size() != 0 || readout_due.size() != 0) @(posedge i_clk);

        squeeze_go <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1:       begin send_idle_pct <= 66; recv_stall_pct <= 0;  end
                2:       begin send_idle_pct <= 0;  recv_stall_pct <= 66; end
                default: begin send_idle_pct <= 34; recv_stall_pct <= 34; end
            endcase
            batch_items = 0;
            while (batch_items < BATCH_ITEMS) queue_session();
            while (key_backlog.size() != 0) @(posedge i_clk);
        end

        while (i_in_valid || readout_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (readout_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", readout_due.size()));
        $display("covered %0d transactions, %0d results, over four idle/stall mixes",
                 items_taken, results_seen);
        $display("runs %0d: finished %0d, aborted %0d; suppressed %0d, cancelled %0d",
                 n_runs, n_finished, n_aborted, n_suppressed, n_cancelled);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("run timed out");
        $display("TB_ERROR");
        $finish;
    end

endmodule
